>>> hdl/vfm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfm_pkg
// Shared types, constants and the corner table of the voxel face mesher.
// ----------------------------------------------------------------------------
package vfm_pkg;

  localparam int CHUNK_EDGE = 16;
  localparam int COORD_W    = 4;
  localparam int KIND_W     = 8;
  localparam int FACE_N     = 6;
  localparam int VERT_W     = 5;
  localparam int FACE_W     = 3;
  localparam int VIDX_W     = 3;
  localparam int AXIS_N     = 3;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  // wide enough for any CHUNK_EDGE in 2..64
  localparam logic [6:0] EDGE_V     = 7'(CHUNK_EDGE);
  localparam logic [6:0] EDGE_LAST  = 7'(CHUNK_EDGE - 1);

  localparam logic       REG_EDGE_LOW  = 1'b0;
  localparam logic       REG_EDGE_HIGH = 1'b1;

  localparam logic [FACE_W-1:0] FACE_LEFT   = 3'd0;
  localparam logic [FACE_W-1:0] FACE_RIGHT  = 3'd1;
  localparam logic [FACE_W-1:0] FACE_BACK   = 3'd2;
  localparam logic [FACE_W-1:0] FACE_FRONT  = 3'd3;
  localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd4;
  localparam logic [FACE_W-1:0] FACE_TOP    = 3'd5;

  localparam logic [VIDX_W-1:0] VERT_LAST = 3'd5;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [KIND_W-1:0]  kind;
    logic [FACE_N-1:0]  faces;
  } voxel_t;

  // corner offset {dz, dy, dx}
  typedef logic [2:0] corner_t;

  localparam corner_t CORNER_TAB [FACE_N][6] = '{
    '{3'b000, 3'b100, 3'b110, 3'b000, 3'b110, 3'b010},  // left
    '{3'b001, 3'b111, 3'b101, 3'b001, 3'b011, 3'b111},  // right
    '{3'b000, 3'b011, 3'b001, 3'b000, 3'b010, 3'b011},  // back
    '{3'b100, 3'b101, 3'b111, 3'b110, 3'b100, 3'b111},  // front
    '{3'b101, 3'b000, 3'b001, 3'b100, 3'b000, 3'b101},  // bottom
    '{3'b111, 3'b011, 3'b010, 3'b110, 3'b111, 3'b010}   // top
  };

  function automatic logic layer_skip(input logic [COORD_W-1:0] c,
                                      input logic lo, input logic hi);
    logic [6:0] cw;
    cw = 7'(c);
    return (cw >= EDGE_V) || (cw == 7'd0 && lo) || (cw == EDGE_LAST && hi);
  endfunction

endpackage

>>> hdl/vfm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfm_front
// Edge mask registers and request classification; culled voxels are dropped.
// ----------------------------------------------------------------------------
module vfm_front
  import vfm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [2:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [COORD_W-1:0] in_vox_x,
  input  logic [COORD_W-1:0] in_vox_y,
  input  logic [COORD_W-1:0] in_vox_z,
  input  logic [KIND_W-1:0]  in_block_kind,
  input  logic [FACE_N-1:0]  in_open_faces,
  input  logic               q_full,
  output logic               q_push,
  output voxel_t             q_data
);

  logic [AXIS_N-1:0] low_mask_r, low_mask_nxt;
  logic [AXIS_N-1:0] high_mask_r, high_mask_nxt;
  logic              skipped;
  logic              emits;

  always_comb begin
    low_mask_nxt  = low_mask_r;
    high_mask_nxt = high_mask_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_EDGE_LOW:  low_mask_nxt  = cfg_wdata;
        REG_EDGE_HIGH: high_mask_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_mask_r  <= '0;
      high_mask_r <= '0;
    end else begin
      low_mask_r  <= low_mask_nxt;
      high_mask_r <= high_mask_nxt;
    end
  end

  always_comb begin
    skipped = layer_skip(in_vox_x, low_mask_r[0], high_mask_r[0]) ||
              layer_skip(in_vox_y, low_mask_r[1], high_mask_r[1]) ||
              layer_skip(in_vox_z, low_mask_r[2], high_mask_r[2]);
    emits   = (in_block_kind != '0) && !skipped && (in_open_faces != '0);

    in_stall = q_full;
    q_push   = in_valid && !q_full && emits;
    q_data   = '{x: in_vox_x, y: in_vox_y, z: in_vox_z,
                 kind: in_block_kind, faces: in_open_faces};
  end

endmodule

>>> hdl/vfm_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfm_fifo
// Small voxel queue between classifier and vertex emitter.
// ----------------------------------------------------------------------------
module vfm_fifo
  import vfm_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  voxel_t push_data,
  output logic   full,
  input  logic   pop,
  output voxel_t pop_data,
  output logic   empty
);

  voxel_t             mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]   count_r, count_nxt;

  always_comb begin
    full       = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
    empty      = (count_r == '0);
    pop_data   = mem[rd_ptr_r];
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop)
      count_nxt = count_r + 1'b1;
    else if (pop && !push)
      count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> hdl/vfm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfm_back
// Walks open faces of the current voxel, one vertex per cycle into out reg while out_stall is low.
// ----------------------------------------------------------------------------
module vfm_back
  import vfm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  voxel_t             q_data,
  input  logic               q_empty,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [VERT_W-1:0]  out_vert_x,
  output logic [VERT_W-1:0]  out_vert_y,
  output logic [VERT_W-1:0]  out_vert_z,
  output logic [KIND_W-1:0]  out_vert_tag,
  output logic [FACE_W-1:0]  out_face_id,
  output logic               out_last_vertex
);

  logic              act_r, act_nxt;
  voxel_t            cur_r, cur_nxt;
  logic [VIDX_W-1:0] vidx_r, vidx_nxt;

  logic              ov_r, ov_nxt;
  logic [VERT_W-1:0] vx_r, vx_nxt, vy_r, vy_nxt, vz_r, vz_nxt;
  logic [KIND_W-1:0] tag_r, tag_nxt;
  logic [FACE_W-1:0] fid_r, fid_nxt;
  logic              lastv_r, lastv_nxt;

  logic [FACE_W-1:0] face_idx;
  logic [FACE_N-1:0] rem_after;
  corner_t           corner;
  logic              adv, emit, face_end, done;

  always_comb begin
    // lowest open face first
    face_idx = FACE_LEFT;
    for (int i = FACE_N - 1; i >= 0; i--) begin
      if (cur_r.faces[i]) face_idx = FACE_W'(i);
    end
    rem_after = cur_r.faces & ~(FACE_N'(1) << face_idx);
    corner    = CORNER_TAB[face_idx][vidx_r];

    adv      = !ov_r || !out_stall;
    emit     = act_r && adv;
    face_end = (vidx_r == VERT_LAST);
    done     = emit && face_end && (rem_after == '0);
    q_pop    = !q_empty && (!act_r || done);

    act_nxt   = act_r;
    cur_nxt   = cur_r;
    vidx_nxt  = vidx_r;
    ov_nxt    = adv ? 1'b0 : ov_r;
    vx_nxt    = vx_r;
    vy_nxt    = vy_r;
    vz_nxt    = vz_r;
    tag_nxt   = tag_r;
    fid_nxt   = fid_r;
    lastv_nxt = lastv_r;

    if (emit) begin
      ov_nxt    = 1'b1;
      vx_nxt    = VERT_W'(cur_r.x) + VERT_W'(corner[0]);
      vy_nxt    = VERT_W'(cur_r.y) + VERT_W'(corner[1]);
      vz_nxt    = VERT_W'(cur_r.z) + VERT_W'(corner[2]);
      tag_nxt   = (face_idx < FACE_BOTTOM) ? (~cur_r.kind + 1'b1) : cur_r.kind;
      fid_nxt   = face_idx;
      lastv_nxt = face_end && (rem_after == '0);
      if (face_end) begin
        vidx_nxt      = '0;
        cur_nxt.faces = rem_after;
      end else begin
        vidx_nxt = vidx_r + 1'b1;
      end
      if (done) act_nxt = 1'b0;
    end

    if (q_pop) begin
      act_nxt  = 1'b1;
      cur_nxt  = q_data;
      vidx_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      ov_r   <= 1'b0;
      vidx_r <= '0;
    end else begin
      act_r  <= act_nxt;
      ov_r   <= ov_nxt;
      vidx_r <= vidx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    vx_r    <= vx_nxt;
    vy_r    <= vy_nxt;
    vz_r    <= vz_nxt;
    tag_r   <= tag_nxt;
    fid_r   <= fid_nxt;
    lastv_r <= lastv_nxt;
  end

  assign out_valid       = ov_r;
  assign out_vert_x      = vx_r;
  assign out_vert_y      = vy_r;
  assign out_vert_z      = vz_r;
  assign out_vert_tag    = tag_r;
  assign out_face_id     = fid_r;
  assign out_last_vertex = lastv_r;

endmodule

>>> hdl/voxel_face_mesh_emitter.sv
`timescale 1ns / 1ps
// With the emitter idle, an accepted voxel passes through the queue and the emitter's voxel register first.
// The emitter gives one vertex per cycle while out_stall is low, six for each open
// face of a voxel; culled voxels are dropped at intake and never reach the emitter.
// Intake runs ahead of the emitter through a 4-entry queue.
// Reset (rst_n low, synchronous) clears edge masks, queue and output valid.
// ----------------------------------------------------------------------------
// voxel_face_mesh_emitter
// Face-culling mesher: six corner vertices for every visible voxel face.
// ----------------------------------------------------------------------------
module voxel_face_mesh_emitter
  import vfm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [2:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [COORD_W-1:0] in_vox_x,
  input  logic [COORD_W-1:0] in_vox_y,
  input  logic [COORD_W-1:0] in_vox_z,
  input  logic [KIND_W-1:0]  in_block_kind,
  input  logic [FACE_N-1:0]  in_open_faces,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [VERT_W-1:0]  out_vert_x,
  output logic [VERT_W-1:0]  out_vert_y,
  output logic [VERT_W-1:0]  out_vert_z,
  output logic [KIND_W-1:0]  out_vert_tag,
  output logic [FACE_W-1:0]  out_face_id,
  output logic               out_last_vertex
);

  logic   q_push, q_full, q_pop, q_empty;
  voxel_t q_wdata, q_rdata;

  vfm_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_vox_x      (in_vox_x),
    .in_vox_y      (in_vox_y),
    .in_vox_z      (in_vox_z),
    .in_block_kind (in_block_kind),
    .in_open_faces (in_open_faces),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_wdata)
  );

  vfm_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  vfm_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_data          (q_rdata),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_vert_x      (out_vert_x),
    .out_vert_y      (out_vert_y),
    .out_vert_z      (out_vert_z),
    .out_vert_tag    (out_vert_tag),
    .out_face_id     (out_face_id),
    .out_last_vertex (out_last_vertex)
  );

endmodule

>>> dv/tb_voxel_face_mesh_emitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_voxel_face_mesh_emitter
// Self-checking bench for the face-culling mesher. Voxel requests go in
// through a valid/stall port. Each accepted request is expanded by a local
// predictor into its vertex list, and that list is matched in order against
// the vertex stream. Both ports idle in random bursts.
// ----------------------------------------------------------------------------
module tb_voxel_face_mesh_emitter;
  import vfm_pkg::*;

  typedef struct packed {
    logic [VERT_W-1:0] x;
    logic [VERT_W-1:0] y;
    logic [VERT_W-1:0] z;
    logic [KIND_W-1:0] tag;
    logic [FACE_W-1:0] face;
    logic              last;
  } vertex_t;

  // corner offset {dx, dy, dz} per face and vertex
  localparam bit [2:0] CORNER_OFS [FACE_N][6] = '{
    '{3'b000, 3'b001, 3'b011, 3'b000, 3'b011, 3'b010},  // left
    '{3'b100, 3'b111, 3'b101, 3'b100, 3'b110, 3'b111},  // right
    '{3'b000, 3'b110, 3'b100, 3'b000, 3'b010, 3'b110},  // back
    '{3'b001, 3'b101, 3'b111, 3'b011, 3'b001, 3'b111},  // front
    '{3'b101, 3'b000, 3'b100, 3'b001, 3'b000, 3'b101},  // bottom
    '{3'b111, 3'b110, 3'b010, 3'b011, 3'b111, 3'b010}   // top
  };

  localparam logic [COORD_W-1:0] LAST_LAYER = COORD_W'(CHUNK_EDGE - 1);

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic               cfg_index;
  logic [2:0]         cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic [COORD_W-1:0] in_vox_x;
  logic [COORD_W-1:0] in_vox_y;
  logic [COORD_W-1:0] in_vox_z;
  logic [KIND_W-1:0]  in_block_kind;
  logic [FACE_N-1:0]  in_open_faces;
  logic               out_valid;
  logic               out_stall;
  logic [VERT_W-1:0]  out_vert_x;
  logic [VERT_W-1:0]  out_vert_y;
  logic [VERT_W-1:0]  out_vert_z;
  logic [KIND_W-1:0]  out_vert_tag;
  logic [FACE_W-1:0]  out_face_id;
  logic               out_last_vertex;

  vertex_t    pending_verts[$];
  logic [2:0] skip_low;
  logic [2:0] skip_high;
  int         fails     = 0;
  int         gap_pct   = 0;
  int         stall_pct = 0;
  int         stall_left = 0;

  voxel_face_mesh_emitter u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_vox_x        (in_vox_x),
    .in_vox_y        (in_vox_y),
    .in_vox_z        (in_vox_z),
    .in_block_kind   (in_block_kind),
    .in_open_faces   (in_open_faces),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_vert_x      (out_vert_x),
    .out_vert_y      (out_vert_y),
    .out_vert_z      (out_vert_z),
    .out_vert_tag    (out_vert_tag),
    .out_face_id     (out_face_id),
    .out_last_vertex (out_last_vertex)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic bit layer_culled(input logic [COORD_W-1:0] c, input bit lo,
                                      input bit hi);
    return (c >= CHUNK_EDGE) || (c == '0 && lo) || (c == LAST_LAYER && hi);
  endfunction

  // expands one voxel into its vertex list, appended to pending_verts
  function automatic void mesh_voxel(input voxel_t v);
    vertex_t vt;
    int      total;
    int      n;
    total = $countones(v.faces) * 6;
    n = 0;
    if (v.kind == '0) return;
    if (layer_culled(v.x, skip_low[0], skip_high[0]) ||
        layer_culled(v.y, skip_low[1], skip_high[1]) ||
        layer_culled(v.z, skip_low[2], skip_high[2])) return;
    for (int f = 0; f < FACE_N; f++) begin
      if (v.faces[f]) begin
        for (int k = 0; k < 6; k++) begin
          vt.x    = VERT_W'(v.x) + VERT_W'(CORNER_OFS[f][k][2]);
          vt.y    = VERT_W'(v.y) + VERT_W'(CORNER_OFS[f][k][1]);
          vt.z    = VERT_W'(v.z) + VERT_W'(CORNER_OFS[f][k][0]);
          vt.face = FACE_W'(f);
          vt.tag  = (vt.face == FACE_BOTTOM || vt.face == FACE_TOP) ?
                    v.kind : KIND_W'(0) - v.kind;
          vt.last = (n == total - 1);
          pending_verts.push_back(vt);
          n++;
        end
      end
    end
  endfunction

  function automatic void cmp_field(input string nm, input logic [7:0] want,
                                    input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, nm, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin : vert_check
    vertex_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_verts.size() == 0) begin
        $display("%0t: unexpected vertex: expected none, actual (%0d,%0d,%0d) face %0d",
                 $time, out_vert_x, out_vert_y, out_vert_z, out_face_id);
        fails++;
      end else begin
        want = pending_verts.pop_front();
        cmp_field("vert_x", 8'(want.x), 8'(out_vert_x));
        cmp_field("vert_y", 8'(want.y), 8'(out_vert_y));
        cmp_field("vert_z", 8'(want.z), 8'(out_vert_z));
        cmp_field("vert_tag", want.tag, out_vert_tag);
        cmp_field("face_id", 8'(want.face), 8'(out_face_id));
        cmp_field("last_vertex", 8'(want.last), 8'(out_last_vertex));
      end
    end
  end

  // receiver back-pressure in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
    end else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_voxel(input voxel_t v);
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_vox_x      <= v.x;
    in_vox_y      <= v.y;
    in_vox_z      <= v.z;
    in_block_kind <= v.kind;
    in_open_faces <= v.faces;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    mesh_voxel(v);
  endtask

  // holds requests until every predicted vertex has come out
  task automatic drain_mesh(input int settle);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_verts.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_edge_masks(input logic [2:0] lo, input logic [2:0] hi);
    // voxels accepted under the old masks may still sit in the intake queue
    drain_mesh(8);
    cfg_we    <= 1'b1;
    cfg_index <= REG_EDGE_LOW;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_index <= REG_EDGE_HIGH;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_we    <= 1'b0;
    skip_low  = lo;
    skip_high = hi;
  endtask

  function automatic voxel_t make_voxel(input int x, input int y, input int z,
                                        input int kind, input int faces);
    voxel_t v;
    v.x     = COORD_W'(x);
    v.y     = COORD_W'(y);
    v.z     = COORD_W'(z);
    v.kind  = KIND_W'(kind);
    v.faces = FACE_N'(faces);
    return v;
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return LAST_LAYER;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic voxel_t random_voxel();
    voxel_t v;
    v.x = pick_coord();
    v.y = pick_coord();
    v.z = pick_coord();
    case ($urandom_range(0, 9))
      0:       v.kind = '0;
      1:       v.kind = '1;
      default: v.kind = KIND_W'($urandom_range(1, 255));
    endcase
    case ($urandom_range(0, 9))
      0:          v.faces = '0;
      1:          v.faces = '1;
      2, 3, 4:    v.faces = FACE_N'($urandom);
      default:    v.faces = FACE_N'(1) << $urandom_range(0, FACE_N - 1);
    endcase
    return v;
  endfunction

  task automatic test_single_faces();
    for (int f = 0; f < FACE_N; f++)
      send_voxel(make_voxel(5, 9, 3, 8'h80 + f * 17, 1 << f));
  endtask

  task automatic test_extremes();
    send_voxel(make_voxel(0, 0, 0, 255, 63));
    send_voxel(make_voxel(15, 15, 15, 1, 63));
    send_voxel(make_voxel(15, 0, 15, 128, 6'b100001));
    send_voxel(make_voxel(0, 15, 0, 127, 6'b011110));
  endtask

  task automatic test_empty_voxels();
    send_voxel(make_voxel(7, 7, 7, 0, 63));
    send_voxel(make_voxel(7, 7, 7, 42, 0));
  endtask

  task automatic test_border_layers();
    set_edge_masks(3'b111, 3'b000);
    send_voxel(make_voxel(0, 4, 4, 9, 1 << FACE_LEFT));
    send_voxel(make_voxel(4, 0, 4, 9, 1 << FACE_BOTTOM));
    send_voxel(make_voxel(4, 4, 0, 9, 1 << FACE_BACK));
    send_voxel(make_voxel(15, 15, 15, 9, 1 << FACE_TOP));
    set_edge_masks(3'b000, 3'b111);
    send_voxel(make_voxel(15, 4, 4, 9, 1 << FACE_RIGHT));
    send_voxel(make_voxel(4, 15, 4, 9, 1 << FACE_TOP));
    send_voxel(make_voxel(4, 4, 15, 9, 1 << FACE_FRONT));
    send_voxel(make_voxel(0, 0, 0, 9, 1 << FACE_LEFT));
    set_edge_masks(3'b010, 3'b101);
    send_voxel(make_voxel(0, 15, 4, 200, 63));
    send_voxel(make_voxel(4, 0, 4, 200, 63));
    send_voxel(make_voxel(15, 4, 4, 200, 63));
  endtask

  task automatic test_random_phase(input int n, input logic [2:0] lo,
                                   input logic [2:0] hi, input int gap,
                                   input int stall);
    set_edge_masks(lo, hi);
    gap_pct   = gap;
    stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      send_voxel(random_voxel());
      if ($urandom_range(0, 49) == 0) drain_mesh(0);
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_EDGE_LOW;
    cfg_wdata     <= '0;
    in_valid      <= 1'b0;
    in_vox_x      <= '0;
    in_vox_y      <= '0;
    in_vox_z      <= '0;
    in_block_kind <= '0;
    in_open_faces <= '0;
    out_stall     <= 1'b0;
    skip_low      = '0;
    skip_high     = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    gap_pct   = 25;
    stall_pct = 25;
    test_single_faces();
    test_extremes();
    test_empty_voxels();
    test_border_layers();

    test_random_phase(70, 3'b000, 3'b000, 20, 20);
    test_random_phase(60, 3'b111, 3'b111, 30, 10);
    test_random_phase(70, 3'($urandom), 3'($urandom), 10, 40);
    test_random_phase(60, 3'b111, 3'b000, 0, 0);
    test_random_phase(70, 3'b000, 3'b111, 40, 40);
    test_random_phase(80, 3'($urandom), 3'($urandom), 15, 25);
    // closing stretch at full rate, no idling
    test_random_phase(60, 3'($urandom), 3'($urandom), 0, 0);

    drain_mesh(10);
    if (fails == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
